FILE: rtl/core/vlff_pkg.sv
// ----------------------------------------------------------------------------
// vlff_pkg : shared types and constants
// Types, codes and sizes used by the voxel light flood fill unit and its cells.
// ----------------------------------------------------------------------------
package vlff_pkg;

   localparam int GRID_SIZE_DEF = 16;
   localparam int COORD_W       = 7;
   localparam int DIST_W        = 5;
   localparam int ACT_W         = 2;

   localparam logic [DIST_W-1:0] MAX_DIST_RESET = 5'd20;

   localparam logic [ACT_W-1:0] ACT_WRITE   = 2'd0;
   localparam logic [ACT_W-1:0] ACT_COMPUTE = 2'd1;
   localparam logic [ACT_W-1:0] ACT_READ    = 2'd2;

   typedef enum logic [2:0] {
      S_CLEAR,
      S_IDLE,
      S_ADDR,
      S_ACCESS,
      S_DATA,
      S_PASS,
      S_DONE
   } state_type;

   typedef struct packed {
      logic              lit;
      logic [DIST_W-1:0] steps;
   } light_type;

   typedef struct packed {
      logic      solid;
      light_type light;
   } elem_type;

   // Control for the centre cell of the chain
   typedef struct packed {
      logic              active;
      logic              src_pass;
      logic [DIST_W-1:0] level;
      logic [DIST_W-1:0] prev_level;
      logic              x_lo;
      logic              x_hi;
      logic              z_lo;
      logic              z_hi;
      logic              t_lo;
      logic              t_hi;
   } centre_ctrl_type;

endpackage

FILE: rtl/core/voxel_light_flood_fill_unit.sv
// ----------------------------------------------------------------------------
// voxel_light_flood_fill_unit : sunlight flood fill over a voxel grid
// Voxel write, light read and undefined action: the request is registered
// and passes the address, access, data and done states; a new request is
// taken only back in idle. Compute: one full stream of the grid through
// the cell chain per distance level, for levels 0 up to max_distance.
// Reset: synchronous; a clearing pass over all N^3 voxels sets the voxel map
// to air before the first item is taken; light reads as unlit until a compute.
// ----------------------------------------------------------------------------
module voxel_light_flood_fill_unit #(
   parameter int GRID_SIZE = vlff_pkg::GRID_SIZE_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [vlff_pkg::ACT_W-1:0]    req_action,
   input  logic [vlff_pkg::COORD_W-1:0]  req_pos_x,
   input  logic [vlff_pkg::COORD_W-1:0]  req_pos_y,
   input  logic [vlff_pkg::COORD_W-1:0]  req_pos_z,
   input  logic                          req_solid,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic                          rsp_lit,
   output logic [vlff_pkg::DIST_W-1:0]   rsp_distance,
   output logic                          rsp_done_res,
   input  logic                          csr_write_en,
   input  logic [vlff_pkg::DIST_W-1:0]   csr_write_data
);

   localparam int PLANE      = GRID_SIZE * GRID_SIZE;
   localparam int DEPTH      = PLANE * GRID_SIZE;
   localparam int AW         = $clog2(DEPTH);
   localparam int CDW        = $clog2(GRID_SIZE);
   localparam int PASS_LAST  = DEPTH + PLANE + 1;
   localparam int CW         = $clog2(PASS_LAST + 1);
   localparam int CW_START   = PLANE + 2;

   vlff_pkg::state_type state_ff, state_in;

   logic [CW-1:0]                cyc_ff, cyc_in;
   logic [vlff_pkg::DIST_W-1:0]  pass_ff, pass_in;
   logic [CDW-1:0]               cx_ff, cx_in, cz_ff, cz_in, ct_ff, ct_in;
   logic [AW-1:0]                wa_ff, wa_in;
   logic [vlff_pkg::ACT_W-1:0]   act_ff, act_in;
   logic [vlff_pkg::COORD_W-1:0] px_ff, px_in, py_ff, py_in, pz_ff, pz_in;
   logic                         solid_ff, solid_in;
   logic [AW-1:0]                addr_ff, addr_in;
   logic                         inrange_ff, inrange_in;
   logic                         computed_ff, computed_in;
   logic [vlff_pkg::DIST_W-1:0]  max_dist_ff;
   logic                         res_lit_ff, res_lit_in;
   logic [vlff_pkg::DIST_W-1:0]  res_dist_ff, res_dist_in;
   logic                         rsp_valid_ff, rsp_valid_in;
   logic                         rsp_lit_ff, rsp_lit_in;
   logic [vlff_pkg::DIST_W-1:0]  rsp_dist_ff, rsp_dist_in;

   // address calculation
   logic                         is_read;
   logic [vlff_pkg::COORD_W-1:0] gx, gy, gz, gt;
   logic                         rng;

   // memories
   logic                         solid_mem [DEPTH];
   vlff_pkg::light_type          light_mem [DEPTH];
   logic                         solid_we;
   logic [AW-1:0]                solid_wa;
   logic                         solid_wd;
   logic                         solid_q_ff;
   vlff_pkg::light_type          light_q_ff;
   logic [AW-1:0]                light_ra;
   logic                         light_we;

   // chain
   logic                         chain_en;
   vlff_pkg::elem_type           head;
   vlff_pkg::centre_ctrl_type    ctrl;
   vlff_pkg::light_type          new_light;
   logic                         centre_active;
   logic                         rsp_free;

   assign rsp_free = !rsp_valid_ff || rsp_ready;

   // ---------------------------------------------------------------------
   // Map a request coordinate to the stream address x + z*N + t*N*N, where
   // t counts rows down from the top so that the row above comes earlier.
   // Reads use padded coordinates: drop the border and shift down by one.
   // ---------------------------------------------------------------------
   always_comb begin
      is_read = (act_ff == vlff_pkg::ACT_READ);
      if (is_read) begin
         rng = (px_ff != '0) && (py_ff != '0) && (pz_ff != '0)
            && (px_ff <= vlff_pkg::COORD_W'(GRID_SIZE))
            && (py_ff <= vlff_pkg::COORD_W'(GRID_SIZE))
            && (pz_ff <= vlff_pkg::COORD_W'(GRID_SIZE));
         gx = px_ff - 7'd1;
         gy = py_ff - 7'd1;
         gz = pz_ff - 7'd1;
      end else begin
         rng = (px_ff < vlff_pkg::COORD_W'(GRID_SIZE))
            && (py_ff < vlff_pkg::COORD_W'(GRID_SIZE))
            && (pz_ff < vlff_pkg::COORD_W'(GRID_SIZE));
         gx = px_ff;
         gy = py_ff;
         gz = pz_ff;
      end
      gt = vlff_pkg::COORD_W'(GRID_SIZE - 1) - gy;
   end

   // ---------------------------------------------------------------------
   // Memories: voxel map and light store share the stream address.
   // ---------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (solid_we) begin
         solid_mem[solid_wa] <= solid_wd;
      end
      solid_q_ff <= solid_mem[cyc_ff[AW-1:0]];
   end

   always_ff @(posedge clock) begin
      if (light_we) begin
         light_mem[wa_ff] <= new_light;
      end
      light_q_ff <= light_mem[light_ra];
   end

   assign light_ra = (state_ff == vlff_pkg::S_PASS) ? cyc_ff[AW-1:0] : addr_ff;

   // ---------------------------------------------------------------------
   // Cell chain: stream every voxel through once per level; the centre cell
   // writes its updated light back at the address it was read from.
   // ---------------------------------------------------------------------
   assign centre_active = (state_ff == vlff_pkg::S_PASS) && (cyc_ff >= CW'(CW_START));
   assign chain_en      = (state_ff == vlff_pkg::S_PASS);
   assign light_we      = centre_active;
   assign head          = '{solid: solid_q_ff, light: light_q_ff};

   always_comb begin
      ctrl.active     = centre_active;
      ctrl.src_pass   = (pass_ff == '0);
      ctrl.level      = pass_ff;
      ctrl.prev_level = pass_ff - 5'd1;
      ctrl.x_lo       = (cx_ff == '0);
      ctrl.x_hi       = (cx_ff == CDW'(GRID_SIZE - 1));
      ctrl.z_lo       = (cz_ff == '0);
      ctrl.z_hi       = (cz_ff == CDW'(GRID_SIZE - 1));
      ctrl.t_lo       = (ct_ff == '0);
      ctrl.t_hi       = (ct_ff == CDW'(GRID_SIZE - 1));
   end

   vlff_chain #(
      .GRID_SIZE (GRID_SIZE)
   ) u_chain (
      .clock     (clock),
      .en        (chain_en),
      .head_in   (head),
      .ctrl      (ctrl),
      .new_light (new_light)
   );

   // ---------------------------------------------------------------------
   // Sequencer
   // ---------------------------------------------------------------------
   always_comb begin
      state_in     = state_ff;
      cyc_in       = cyc_ff;
      pass_in      = pass_ff;
      cx_in        = cx_ff;
      cz_in        = cz_ff;
      ct_in        = ct_ff;
      wa_in        = wa_ff;
      act_in       = act_ff;
      px_in        = px_ff;
      py_in        = py_ff;
      pz_in        = pz_ff;
      solid_in     = solid_ff;
      addr_in      = addr_ff;
      inrange_in   = inrange_ff;
      computed_in  = computed_ff;
      res_lit_in   = res_lit_ff;
      res_dist_in  = res_dist_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_lit_in   = rsp_lit_ff;
      rsp_dist_in  = rsp_dist_ff;
      req_ready    = 1'b0;
      solid_we     = 1'b0;
      solid_wa     = addr_ff;
      solid_wd     = solid_ff;

      unique case (state_ff)
         vlff_pkg::S_CLEAR: begin
            // sweep the voxel map to air
            solid_we = 1'b1;
            solid_wa = cyc_ff[AW-1:0];
            solid_wd = 1'b0;
            cyc_in   = cyc_ff + 1'b1;
            if (cyc_ff == CW'(DEPTH - 1)) begin
               cyc_in   = '0;
               state_in = vlff_pkg::S_IDLE;
            end
         end
         vlff_pkg::S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               act_in   = req_action;
               px_in    = req_pos_x;
               py_in    = req_pos_y;
               pz_in    = req_pos_z;
               solid_in = req_solid;
               state_in = vlff_pkg::S_ADDR;
            end
         end
         vlff_pkg::S_ADDR: begin
            addr_in    = AW'(gx) + AW'(gz) * AW'(GRID_SIZE) + AW'(gt) * AW'(PLANE);
            inrange_in = rng;
            if (act_ff == vlff_pkg::ACT_COMPUTE) begin
               cyc_in   = '0;
               pass_in  = '0;
               cx_in    = '0;
               cz_in    = '0;
               ct_in    = '0;
               wa_in    = '0;
               state_in = vlff_pkg::S_PASS;
            end else begin
               state_in = vlff_pkg::S_ACCESS;
            end
         end
         vlff_pkg::S_ACCESS: begin
            // write voxels in range; reads wait here for the registered store output
            solid_we = (act_ff == vlff_pkg::ACT_WRITE) && inrange_ff;
            state_in = vlff_pkg::S_DATA;
         end
         vlff_pkg::S_DATA: begin
            res_lit_in  = is_read && inrange_ff && computed_ff && light_q_ff.lit;
            res_dist_in = res_lit_in ? light_q_ff.steps : '0;
            state_in    = vlff_pkg::S_DONE;
         end
         vlff_pkg::S_PASS: begin
            cyc_in = cyc_ff + 1'b1;
            if (centre_active) begin
               wa_in = wa_ff + 1'b1;
               cx_in = cx_ff + 1'b1;
               if (cx_ff == CDW'(GRID_SIZE - 1)) begin
                  cx_in = '0;
                  cz_in = cz_ff + 1'b1;
                  if (cz_ff == CDW'(GRID_SIZE - 1)) begin
                     cz_in = '0;
                     ct_in = ct_ff + 1'b1;
                  end
               end
            end
            if (cyc_ff == CW'(PASS_LAST)) begin
               cyc_in = '0;
               cx_in  = '0;
               cz_in  = '0;
               ct_in  = '0;
               wa_in  = '0;
               if (pass_ff == max_dist_ff) begin
                  computed_in = 1'b1;
                  res_lit_in  = 1'b0;
                  res_dist_in = '0;
                  state_in    = vlff_pkg::S_DONE;
               end else begin
                  pass_in = pass_ff + 1'b1;
               end
            end
         end
         vlff_pkg::S_DONE: begin
            // hold until the output register is free
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               rsp_lit_in   = res_lit_ff;
               rsp_dist_in  = res_dist_ff;
               res_lit_in   = 1'b0;
               res_dist_in  = '0;
               state_in     = vlff_pkg::S_IDLE;
            end
         end
         default: begin
            state_in = vlff_pkg::S_IDLE;
         end
      endcase
      if (state_ff == vlff_pkg::S_ACCESS || state_ff == vlff_pkg::S_ADDR) begin
         res_lit_in  = 1'b0;
         res_dist_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= vlff_pkg::S_CLEAR;
         cyc_ff       <= '0;
         pass_ff      <= '0;
         cx_ff        <= '0;
         cz_ff        <= '0;
         ct_ff        <= '0;
         wa_ff        <= '0;
         computed_ff  <= 1'b0;
         max_dist_ff  <= vlff_pkg::MAX_DIST_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cyc_ff       <= cyc_in;
         pass_ff      <= pass_in;
         cx_ff        <= cx_in;
         cz_ff        <= cz_in;
         ct_ff        <= ct_in;
         wa_ff        <= wa_in;
         computed_ff  <= computed_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_write_en) begin
            max_dist_ff <= csr_write_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      act_ff      <= act_in;
      px_ff       <= px_in;
      py_ff       <= py_in;
      pz_ff       <= pz_in;
      solid_ff    <= solid_in;
      addr_ff     <= addr_in;
      inrange_ff  <= inrange_in;
      res_lit_ff  <= res_lit_in;
      res_dist_ff <= res_dist_in;
      rsp_lit_ff  <= rsp_lit_in;
      rsp_dist_ff <= rsp_dist_in;
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_lit      = rsp_lit_ff;
   assign rsp_distance = rsp_dist_ff;
   assign rsp_done_res = 1'b1;

endmodule

FILE: rtl/core/vlff_cell.sv
// ----------------------------------------------------------------------------
// vlff_cell : one stage of the voxel chain
// Holds one streamed voxel (solid bit and light) and hands it on.
// ----------------------------------------------------------------------------
module vlff_cell (
   input  logic               clock,
   input  logic               en,
   input  vlff_pkg::elem_type d_in,
   output vlff_pkg::elem_type q_out
);

   vlff_pkg::elem_type elem_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         elem_ff <= d_in;
      end
   end

   assign q_out = elem_ff;

endmodule

FILE: rtl/core/vlff_chain.sv
// ----------------------------------------------------------------------------
// vlff_chain : sliding window over the voxel stream
// A row of 2*N*N+1 cells; the centre sees its six face neighbours at fixed
// taps and is replaced by its updated light before moving on.
// ----------------------------------------------------------------------------
module vlff_chain #(
   parameter int GRID_SIZE = vlff_pkg::GRID_SIZE_DEF
) (
   input  logic                      clock,
   input  logic                      en,
   input  vlff_pkg::elem_type        head_in,
   input  vlff_pkg::centre_ctrl_type ctrl,
   output vlff_pkg::light_type       new_light
);

   localparam int CENTRE    = GRID_SIZE * GRID_SIZE;
   localparam int CHAIN_LEN = 2 * CENTRE + 1;

   vlff_pkg::elem_type q   [CHAIN_LEN];
   vlff_pkg::elem_type d   [CHAIN_LEN];
   vlff_pkg::elem_type centre_out;
   vlff_pkg::elem_type nb  [6];
   logic               nb_ok [6];
   logic               hit;

   always_comb begin
      // later cells in the stream sit towards the head, earlier ones beyond
      nb[0] = q[CENTRE-1];          nb_ok[0] = !ctrl.x_hi;
      nb[1] = q[CENTRE+1];          nb_ok[1] = !ctrl.x_lo;
      nb[2] = q[CENTRE-GRID_SIZE];  nb_ok[2] = !ctrl.z_hi;
      nb[3] = q[CENTRE+GRID_SIZE];  nb_ok[3] = !ctrl.z_lo;
      nb[4] = q[0];                 nb_ok[4] = !ctrl.t_hi;
      nb[5] = q[2*CENTRE];          nb_ok[5] = !ctrl.t_lo;
      hit = 1'b0;
      for (int k = 0; k < 6; k++) begin
         hit = hit | (nb_ok[k] & nb[k].light.lit & (nb[k].light.steps == ctrl.prev_level));
      end
      new_light = q[CENTRE].light;
      if (ctrl.src_pass) begin
         new_light.lit   = !q[CENTRE].solid & (ctrl.t_lo | q[2*CENTRE].light.lit);
         new_light.steps = '0;
      end else if (!q[CENTRE].light.lit && !q[CENTRE].solid && hit) begin
         new_light.lit   = 1'b1;
         new_light.steps = ctrl.level;
      end
      centre_out       = q[CENTRE];
      centre_out.light = ctrl.active ? new_light : q[CENTRE].light;
   end

   generate
      for (genvar j = 0; j < CHAIN_LEN; j++) begin : g_cell
         if (j == 0) begin : g_head
            assign d[j] = head_in;
         end else if (j == CENTRE + 1) begin : g_after
            assign d[j] = centre_out;
         end else begin : g_mid
            assign d[j] = q[j-1];
         end
         vlff_cell u_cell (
            .clock (clock),
            .en    (en),
            .d_in  (d[j]),
            .q_out (q[j])
         );
      end
   endgenerate

endmodule
